// ----- src/pib_pkg.sv -----
// Package for the page image blit shifter.
// Register index codes and fixed field widths; no dependencies.
package pib_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 8;
	localparam int unsigned CNT_W     = 5;	// page and row counters
	localparam int unsigned SUM_W     = 10;	// placement sums

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_COLUMN = 3'd0,
		REG_ORIGIN_ROW    = 3'd1,
		REG_IMAGE_WIDTH   = 3'd2,
		REG_IMAGE_HEIGHT  = 3'd3,
		REG_INVERT_ENABLE = 3'd4,
		REG_COLUMN_OFFSET = 3'd5
	} cfg_reg_t;

endpackage

// ----- src/page_image_blit_shifter_top.sv -----
// Page image blit shifter top level: counters, line store and output register.
// Depends on pib_pkg and pib_ram.
//
//   channel  dir  fields (low bit up)                          handshake
//   s_*      in   image_byte[7:0]                              tvalid/tready
//   m_*      out  page_byte, display_column, display_page;     tvalid/tready
//                 tlast = last_byte
//   cfg_*    in   cfg_index selects register, cfg_data value   cfg_we
//
// One word per cycle while the output is not stalled; a taken word passes the
// first stage, which also registers the line store read, and then the output
// register before m_tvalid rises. arst_n clears counters and valid flags and
// presets the config registers; the line store is not cleared.
// A stalled output holds one word in m_*, one more in the first stage, then
// s_tready drops. Words taken under an invalid placement give no output.
module page_image_blit_shifter_top #(
	parameter int unsigned DISPLAY_WIDTH  = 128,
	parameter int unsigned DISPLAY_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,	// image_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,	// page_byte[7:0], display_column[15:8],
					// display_page[18:16], zero[23:19]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [pib_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pib_pkg::CFG_DAT_W-1:0] cfg_data
);

	import pib_pkg::*;

	localparam int unsigned CW = $clog2(DISPLAY_WIDTH);

	// configuration
	logic [6:0] origin_column_q;
	logic [5:0] origin_row_q;
	logic [7:0] image_width_q;
	logic [6:0] image_height_q;
	logic       invert_enable_q;
	logic [2:0] column_offset_q;

	// blit counters
	logic [CW-1:0]    col_q;
	logic [CNT_W-1:0] page_q;
	logic [CNT_W-1:0] rows_q;

	// first stage
	logic          valid_s1;
	logic [7:0]    img_s1;
	logic [2:0]    shift_s1;
	logic          spill_s1;
	logic          tail_s1;
	logic          invert_s1;
	logic          last_s1;
	logic [7:0]    dcol_s1;
	logic [2:0]    dpage_s1;
	logic [7:0]    store_rd;

	logic accept, out_load, blit_ok, restart, tail_c, last_c, wrap_c;
	logic [SUM_W-1:0] col_end, row_end, col_ext, col_inc;
	logic [7:0]       row_sum;
	logic [CNT_W-1:0] last_page, pages, rows, eff_page, eff_rows;
	logic [2:0]       first_page;
	logic [CW-1:0]    eff_col;
	logic [7:0]       spill, merged, page_byte;

	// placement and page arithmetic
	always_comb begin
		col_end    = SUM_W'(origin_column_q) + SUM_W'(image_width_q);
		row_end    = SUM_W'(origin_row_q) + SUM_W'(image_height_q);
		blit_ok    = (image_width_q != 8'd0) && (image_height_q != 7'd0) &&
		             (col_end <= SUM_W'(DISPLAY_WIDTH)) &&
		             (row_end <= SUM_W'(DISPLAY_HEIGHT));
		row_sum    = {2'b00, origin_row_q} + {1'b0, image_height_q} - 8'd1;
		last_page  = CNT_W'(row_sum >> 3);
		first_page = origin_row_q[5:3];
		pages      = last_page - CNT_W'(first_page) + CNT_W'(1);
		rows       = CNT_W'(({1'b0, image_height_q} + 8'd7) >> 3);

		restart  = (SUM_W'(col_q) >= SUM_W'(image_width_q)) || (page_q >= pages);
		eff_col  = restart ? '0 : col_q;
		eff_page = restart ? '0 : page_q;
		eff_rows = restart ? '0 : rows_q;
		tail_c   = (eff_rows >= rows);
		col_ext  = SUM_W'(eff_col);
		col_inc  = col_ext + SUM_W'(1);
		wrap_c   = (col_inc == SUM_W'(image_width_q));
		last_c   = (eff_page + CNT_W'(1) == pages) && wrap_c;
	end

	assign out_load = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || out_load;
	assign accept   = s_tvalid && s_tready;

	// configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_column_q <= '0;
			origin_row_q    <= '0;
			image_width_q   <= 8'd1;
			image_height_q  <= 7'd1;
			invert_enable_q <= 1'b0;
			column_offset_q <= 3'd2;
			col_q           <= '0;
			page_q          <= '0;
			rows_q          <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_COLUMN: origin_column_q <= cfg_data[6:0];
				REG_ORIGIN_ROW:    origin_row_q    <= cfg_data[5:0];
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_data[7:0];
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[6:0];
				REG_INVERT_ENABLE: invert_enable_q <= cfg_data[0];
				REG_COLUMN_OFFSET: column_offset_q <= cfg_data[2:0];
				default: ;
			endcase
			if (cfg_index <= REG_COLUMN_OFFSET) begin
				col_q  <= '0;
				page_q <= '0;
				rows_q <= '0;
			end
		end else if (accept && blit_ok) begin
			if (wrap_c) begin
				col_q <= '0;
				if (eff_page + CNT_W'(1) >= pages) begin
					page_q <= '0;
					rows_q <= '0;
				end else begin
					page_q <= eff_page + CNT_W'(1);
					rows_q <= tail_c ? eff_rows : eff_rows + CNT_W'(1);
				end
			end else begin
				col_q  <= col_inc[CW-1:0];
				page_q <= eff_page;
				rows_q <= eff_rows;
			end
		end
	end

	// line store: read old byte and write new one at the same column
	pib_ram #(
		.WIDTH (8),
		.DEPTH (DISPLAY_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (accept && blit_ok && !tail_c),
		.waddr (eff_col),
		.wdata (s_tdata),
		.re    (accept && blit_ok),
		.raddr (eff_col),
		.rdata (store_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= blit_ok;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			img_s1    <= s_tdata;
			shift_s1  <= origin_row_q[2:0];
			spill_s1  <= (eff_page != '0);
			tail_s1   <= tail_c;
			invert_s1 <= invert_enable_q;
			last_s1   <= last_c;
			dcol_s1   <= col_end[7:0] - image_width_q +
			             (col_ext[7:0] + {5'd0, column_offset_q});
			dpage_s1  <= first_page + eff_page[2:0];
		end
	end

	// merge shifted byte with spill of the row above
	always_comb begin
		spill     = store_rd >> (4'd8 - {1'b0, shift_s1});
		merged    = 8'(img_s1 << shift_s1) | (spill_s1 ? spill : 8'd0);
		page_byte = tail_s1 ? spill : merged;
		if (invert_s1) begin
			page_byte = ~page_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {5'd0, dpage_s1, dcol_s1, page_byte};
			m_tlast <= last_s1;
		end
	end

endmodule

// ----- src/pib_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module pib_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
